>>> rtl/sdq_pkg.sv
// sdq_pkg: shared types and constants of the sorted deadline queue
// used by sdq_ctrl, sdq_dp and sorted_deadline_queue
package sdq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned PtrW  = $clog2(Depth);

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_EXPIRE = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  // date fields lead so the top 23 bits form the sort key
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] subject;
    logic [7:0]  expn;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_CMP,
    S_INS_PUT,
    S_EMIT,
    S_EXP_RD,
    S_EXP_CMP,
    S_EXP_FIN,
    S_RM_CHK,
    S_RM_CMP,
    S_RM_SH,
    S_RM_MV
  } state_e;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rsel_e;

  typedef struct packed {
    logic    latch;
    logic    idx_load_count;
    logic    idx_clear;
    logic    idx_dec;
    logic    idx_inc;
    logic    rd_en;
    rsel_e   rsel;
    logic    wr_en;
    logic    wr_new;
    logic    head_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_load;
    logic    pend_clear;
    logic    emit;
    logic    emit_pend;
    status_e status;
    logic    last;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    full;
    logic    empty;
    logic    idx_zero;
    logic    idx_at_count;
    logic    next_at_count;
    logic    key_ge;
    logic    match;
    logic    out_free;
    logic    pend_v;
    cnt_t    count;
  } stat_t;

endpackage

>>> rtl/sdq_dp.sv
// sdq_dp: entry memory (circular), request, pending and output registers
// depends on sdq_pkg; driven by sdq_ctrl commands
module sdq_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdq_pkg::cmd_t     cmd_i,
  output sdq_pkg::stat_t    stat_o,
  input  logic [1:0]        action_i,
  input  logic [4:0]        due_day_i,
  input  logic [3:0]        due_month_i,
  input  logic [13:0]       due_year_i,
  input  logic [15:0]       subject_id_i,
  input  logic [7:0]        exp_number_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [4:0]        out_day_o,
  output logic [3:0]        out_month_o,
  output logic [13:0]       out_year_o,
  output logic [15:0]       out_subject_o,
  output logic [7:0]        out_exp_o,
  output logic [4:0]        fill_o,
  output logic              last_o
);

  sdq_pkg::entry_t mem [sdq_pkg::Depth];
  sdq_pkg::entry_t req_q, rd_q, pend_q, out_q;
  sdq_pkg::action_e act_q;
  sdq_pkg::cnt_t   idx_q, count_q, pend_fill_q, lrd;
  sdq_pkg::ptr_t   head_q, ra, wa;
  logic            pend_v_q, out_valid_q, last_q;
  logic [2:0]      status_q;
  logic [4:0]      fill_q;

  function automatic sdq_pkg::ptr_t phys(sdq_pkg::ptr_t head, sdq_pkg::cnt_t l);
    logic [sdq_pkg::CntW:0] s;
    s = (sdq_pkg::CntW+1)'(head) + (sdq_pkg::CntW+1)'(l[sdq_pkg::PtrW-1:0]);
    if (s >= (sdq_pkg::CntW+1)'(sdq_pkg::Depth)) begin
      s = s - (sdq_pkg::CntW+1)'(sdq_pkg::Depth);
    end
    return s[sdq_pkg::PtrW-1:0];
  endfunction

  always_comb begin
    case (cmd_i.rsel)
      sdq_pkg::RD_PREV: lrd = idx_q - sdq_pkg::CntW'(1);
      sdq_pkg::RD_NEXT: lrd = idx_q + sdq_pkg::CntW'(1);
      default:          lrd = idx_q;
    endcase
  end

  assign ra = phys(head_q, lrd);
  assign wa = phys(head_q, idx_q);

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wa] <= cmd_i.wr_new ? req_q : rd_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= '{year: due_year_i, month: due_month_i, day: due_day_i,
                 subject: subject_id_i, expn: exp_number_i};
      act_q <= sdq_pkg::action_e'(action_i);
    end
    if (cmd_i.pend_load) begin
      pend_q      <= rd_q;
      pend_fill_q <= count_q - sdq_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      head_q   <= '0;
      count_q  <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.idx_load_count) begin
        idx_q <= count_q;
      end else if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_q - sdq_pkg::CntW'(1);
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + sdq_pkg::CntW'(1);
      end
      if (cmd_i.head_inc) begin
        head_q <= (head_q == sdq_pkg::PtrW'(sdq_pkg::Depth - 1)) ? '0
                : head_q + sdq_pkg::PtrW'(1);
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + sdq_pkg::CntW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - sdq_pkg::CntW'(1);
      end
      if (cmd_i.pend_load) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.pend_clear) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      out_q    <= cmd_i.emit_pend ? pend_q : '0;
      fill_q   <= 5'(cmd_i.emit_pend ? pend_fill_q : count_q);
      last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_day_o     = out_q.day;
  assign out_month_o   = out_q.month;
  assign out_year_o    = out_q.year;
  assign out_subject_o = out_q.subject;
  assign out_exp_o     = out_q.expn;
  assign fill_o        = fill_q;
  assign last_o        = last_q;

  assign stat_o.action        = act_q;
  assign stat_o.full          = (count_q == sdq_pkg::CntW'(sdq_pkg::Depth));
  assign stat_o.empty         = (count_q == '0);
  assign stat_o.idx_zero      = (idx_q == '0);
  assign stat_o.idx_at_count  = (idx_q == count_q);
  assign stat_o.next_at_count = ((idx_q + sdq_pkg::CntW'(1)) == count_q);
  assign stat_o.key_ge        = ({rd_q.year, rd_q.month, rd_q.day}
                                 >= {req_q.year, req_q.month, req_q.day});
  assign stat_o.match         = (rd_q.subject == req_q.subject) && (rd_q.expn == req_q.expn);
  assign stat_o.out_free      = !out_valid_q || out_ready_i;
  assign stat_o.pend_v        = pend_v_q;
  assign stat_o.count         = count_q;

endmodule

>>> rtl/sdq_ctrl.sv
// sdq_ctrl: sequencer for insert, expire and remove
// depends on sdq_pkg; commands sdq_dp
module sdq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdq_pkg::stat_t stat_i,
  output sdq_pkg::cmd_t  cmd_o
);

  sdq_pkg::state_e  state_q, state_d;
  sdq_pkg::status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdq_pkg::S_IDLE;
      st_q    <= sdq_pkg::ST_INSERTED;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    cmd_o      = '0;
    cmd_o.rsel = sdq_pkg::RD_CUR;
    in_ready_o = 1'b0;
    case (state_q)
      sdq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = sdq_pkg::S_DISPATCH;
        end
      end
      sdq_pkg::S_DISPATCH: begin
        case (stat_i.action)
          sdq_pkg::ACT_INSERT: begin
            if (stat_i.full) begin
              st_d    = sdq_pkg::ST_FULL;
              state_d = sdq_pkg::S_EMIT;
            end else begin
              cmd_o.idx_load_count = 1'b1;
              state_d              = sdq_pkg::S_INS_CHK;
            end
          end
          sdq_pkg::ACT_EXPIRE: begin
            cmd_o.idx_clear = 1'b1;
            state_d         = sdq_pkg::S_EXP_RD;
          end
          sdq_pkg::ACT_REMOVE: begin
            cmd_o.idx_clear = 1'b1;
            state_d         = sdq_pkg::S_RM_CHK;
          end
          default: state_d = sdq_pkg::S_IDLE;
        endcase
      end
      sdq_pkg::S_INS_CHK: begin
        if (stat_i.idx_zero) begin
          state_d = sdq_pkg::S_INS_PUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rsel  = sdq_pkg::RD_PREV;
          state_d     = sdq_pkg::S_INS_CMP;
        end
      end
      sdq_pkg::S_INS_CMP: begin
        if (stat_i.key_ge) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.idx_dec = 1'b1;
          state_d       = sdq_pkg::S_INS_CHK;
        end else begin
          state_d = sdq_pkg::S_INS_PUT;
        end
      end
      sdq_pkg::S_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        st_d          = sdq_pkg::ST_INSERTED;
        state_d       = sdq_pkg::S_EMIT;
      end
      sdq_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = st_q;
          cmd_o.last   = 1'b1;
          state_d      = sdq_pkg::S_IDLE;
        end
      end
      sdq_pkg::S_EXP_RD: begin
        if (stat_i.empty) begin
          state_d = sdq_pkg::S_EXP_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = sdq_pkg::S_EXP_CMP;
        end
      end
      sdq_pkg::S_EXP_CMP: begin
        if (stat_i.key_ge) begin
          state_d = sdq_pkg::S_EXP_FIN;
        end else if (!stat_i.pend_v || stat_i.out_free) begin
          cmd_o.emit      = stat_i.pend_v;
          cmd_o.emit_pend = 1'b1;
          cmd_o.status    = sdq_pkg::ST_EXPIRED;
          cmd_o.pend_load = 1'b1;
          cmd_o.head_inc  = 1'b1;
          cmd_o.cnt_dec   = 1'b1;
          state_d         = sdq_pkg::S_EXP_RD;
        end
      end
      sdq_pkg::S_EXP_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (stat_i.pend_v) begin
            cmd_o.emit_pend  = 1'b1;
            cmd_o.pend_clear = 1'b1;
            cmd_o.status     = sdq_pkg::ST_EXPIRED;
          end else begin
            cmd_o.status = sdq_pkg::ST_NONE;
          end
          state_d = sdq_pkg::S_IDLE;
        end
      end
      sdq_pkg::S_RM_CHK: begin
        if (stat_i.idx_at_count) begin
          st_d    = sdq_pkg::ST_NOTFOUND;
          state_d = sdq_pkg::S_EMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = sdq_pkg::S_RM_CMP;
        end
      end
      sdq_pkg::S_RM_CMP: begin
        if (stat_i.match) begin
          state_d = sdq_pkg::S_RM_SH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = sdq_pkg::S_RM_CHK;
        end
      end
      sdq_pkg::S_RM_SH: begin
        if (stat_i.next_at_count) begin
          cmd_o.cnt_dec = 1'b1;
          st_d          = sdq_pkg::ST_REMOVED;
          state_d       = sdq_pkg::S_EMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rsel  = sdq_pkg::RD_NEXT;
          state_d     = sdq_pkg::S_RM_MV;
        end
      end
      sdq_pkg::S_RM_MV: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = sdq_pkg::S_RM_SH;
      end
      default: state_d = sdq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/sorted_deadline_queue.sv
// sorted_deadline_queue: date-ordered queue with insert, expire and remove
// depends on sdq_pkg, sdq_ctrl and sdq_dp
//
//  channel | handshake              | payload
//  in      | in_valid_i / in_ready_o | action, due date, subject_id, exp_number
//  out     | out_valid_o/out_ready_i | status, expired entry, fill, last
//
// one request at a time; the entry memory gives one read and one write a cycle
// insert: k entries at or after the new date each move up one place before the write
// remove: p entries scanned, s entries after the match shifted down one place
// expire: pops head entries before the request date; one at or after it stops the scan
// a waiting result stalls the sequencer only when the next result is ready
// reset clears count, head and handshake state; the memory holds no reset
module sorted_deadline_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [4:0]  due_day_i,
  input  logic [3:0]  due_month_i,
  input  logic [13:0] due_year_i,
  input  logic [15:0] subject_id_i,
  input  logic [7:0]  exp_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [4:0]  out_day_o,
  output logic [3:0]  out_month_o,
  output logic [13:0] out_year_o,
  output logic [15:0] out_subject_o,
  output logic [7:0]  out_exp_o,
  output logic [4:0]  fill_o,
  output logic        last_o
);

  sdq_pkg::cmd_t  cmd;
  sdq_pkg::stat_t stat;

  // sequencer: walks the memory one entry per step
  sdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, compares and the output register
  sdq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .due_day_i     (due_day_i),
    .due_month_i   (due_month_i),
    .due_year_i    (due_year_i),
    .subject_id_i  (subject_id_i),
    .exp_number_i  (exp_number_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_day_o     (out_day_o),
    .out_month_o   (out_month_o),
    .out_year_o    (out_year_o),
    .out_subject_o (out_subject_o),
    .out_exp_o     (out_exp_o),
    .fill_o        (fill_o),
    .last_o        (last_o)
  );

  // occupancy never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= sdq_pkg::CntW'(sdq_pkg::Depth))
    else $error("entry count above capacity");

  // an accepted request keeps the sequencer busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  // no expired entry is left pending once the sequencer is idle
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.pend_v)
    else $error("pending expired entry while idle");

endmodule
